// ===== src/sm3_pkg.sv =====
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CountWidth = 30;
   localparam logic [CountWidth-1:0] ByteLimit = 30'd536870911;
   localparam logic [WordWidth-1:0] TConstLow  = 32'h79cc4519;
   localparam logic [WordWidth-1:0] TConstHigh = 32'h7a879d8a;
   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [7:0] chain_type;

   localparam chain_type SM3_IV = '{
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_type;

   typedef struct packed {
      word_type digest_word0;
      word_type digest_word1;
      word_type digest_word2;
      word_type digest_word3;
      word_type digest_word4;
      word_type digest_word5;
      word_type digest_word6;
      word_type digest_word7;
      logic     too_long;
   } rsp_type;

   // control from sequencer into the compression engine
   typedef struct packed {
      logic start;
   } cmp_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_sts_type;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [2*WordWidth-1:0] d;
      d = {x, x} << n;
      return d[2*WordWidth-1:WordWidth];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
   endfunction

endpackage

// ===== src/sm3_round.sv =====
// One SM3 compression unit: a single round datapath used 64 times per block,
// with a rolling 16-word expansion window that yields W[j] and W[j+4].
module sm3_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sm3_pkg::cmp_ctl_type   ctl,
   output sm3_pkg::cmp_sts_type   sts,
   input  sm3_pkg::word_type [15:0] block,
   input  sm3_pkg::chain_type     chain_in,
   output sm3_pkg::chain_type     chain_out
);
   import sm3_pkg::*;

   word_type [15:0] w_ff, w_in;
   chain_type v_ff, v_in;
   logic [5:0] round_ff, round_in;
   logic busy_ff, busy_in, done_ff, done_in;

   word_type a, b, c, d, e, f, g, h;
   word_type a12, ss1, ss2, ff_v, gg_v, tt1, tt2, tc, w_new, wj, wj4;

   always_comb begin
      {h, g, f, e, d, c, b, a} = v_ff;
      wj  = w_ff[0];
      wj4 = w_ff[4];
      tc  = rotl((round_ff < 6'd16) ? TConstLow : TConstHigh, round_ff[4:0]);
      a12 = rotl(a, 5'd12);
      ss1 = rotl(a12 + e + tc, 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff_v = a ^ b ^ c;
         gg_v = e ^ f ^ g;
      end else begin
         ff_v = (a & b) | (a & c) | (b & c);
         gg_v = (e & f) | (~e & g);
      end
      tt1 = ff_v + d + ss2 + (wj ^ wj4);
      tt2 = gg_v + h + ss1 + wj;
      // W[j+16] from the window
      w_new = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15))
            ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];

      w_in     = w_ff;
      v_in     = v_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         w_in     = block;
         v_in     = chain_in;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         w_in     = {w_new, w_ff[15:1]};
         v_in     = {g, rotl(f, 5'd19), e, perm0(tt2), c, rotl(b, 5'd9), a, tt1};
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      v_ff     <= v_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign chain_out = v_ff;

endmodule

// ===== src/sm3_hash_stream_top.sv =====
// SM3 streaming hash. A byte that does not fill a block is taken without a stall;
// a byte that completes a 64-byte block stalls the input while the block compresses
// (the unit is started, runs 64 rounds in the shared round unit, then the chain is updated).
// A last beat pads with one or two compressions before the result, or flags too_long
// with no compression if the byte count overflowed. Synchronous active-high reset
// loads the IV, clears counts.
module sm3_hash_stream_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sm3_pkg::rsp_type rsp_data
);
   import sm3_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,  // take bytes
      ST_BLK   = 5'b00010,  // data block compressing
      ST_PAD1  = 5'b00100,  // first pad block compressing (pos >= 56)
      ST_PAD2  = 5'b01000,  // final block compressing
      ST_OUT   = 5'b10000   // result waiting
   } state_type;

   state_type state_ff, state_in;
   word_type [15:0] buf_ff, buf_in;
   chain_type chain_ff, chain_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic last_ff, last_in;   // finalize pending after a block compression; in the pad states, start pending
   rsp_type out_ff, out_in;

   // The block-full byte lands in buf_ff at the accepting edge, so the unit
   // is started from ST_BLK's first cycle, once the buffer holds the block.
   logic blk_go_ff;

   cmp_ctl_type ctl;
   cmp_sts_type sts;
   chain_type   cmp_out, chain_next;

   sm3_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .block    (buf_ff),
      .chain_in (chain_ff),
      .chain_out(cmp_out)
   );

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = out_ff;

   always_comb begin
      for (int k = 0; k < 8; k++) chain_next[k] = chain_ff[k] ^ cmp_out[k];
   end

   // pad the buffer from byte position pos: 0x80, then zeros
   function automatic word_type [15:0] pad_buf(input word_type [15:0] bi,
                                                input logic [5:0] pos);
      word_type [15:0] r;
      r = bi;
      for (int p = 0; p < 64; p++) begin
         if (p[5:0] == pos) r[p/4][(3-p%4)*8 +: 8] = PadByte;
         else if (p[5:0] > pos) r[p/4][(3-p%4)*8 +: 8] = 8'h00;
      end
      return r;
   endfunction

   logic [5:0] pos;
   logic take_byte;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      out_in   = out_ff;
      ctl.start = 1'b0;
      pos       = count_ff[5:0];
      take_byte = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // byte stage
               if (req_data.byte_present && !ovf_ff) begin
                  if (count_ff >= ByteLimit) ovf_in = 1'b1;
                  else begin
                     take_byte = 1'b1;
                     buf_in[pos[5:2]][(2'd3 - pos[1:0])*8 +: 8] = req_data.data_byte;
                     count_in = count_ff + 1'b1;
                  end
               end
               if (take_byte && pos == 6'd63) begin
                  // unit starts next cycle, after the byte is in buf_ff
                  last_in   = req_data.last;
                  state_in  = ST_BLK;
               end else if (req_data.last) begin
                  if (ovf_in) begin
                     out_in   = '0;
                     out_in.too_long = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     // finalize on count_in
                     buf_in = pad_buf(buf_in, count_in[5:0]);
                     if (count_in[5:0] >= 6'd56) state_in = ST_PAD1;
                     else begin
                        buf_in[14] = '0;
                        buf_in[15] = {count_in[28:0], 3'b000};
                        state_in   = ST_PAD2;
                     end
                     last_in = 1'b1;  // start next cycle
                  end
               end
            end
         end
         ST_BLK: begin
            ctl.start = blk_go_ff;
            if (sts.done) begin
               chain_in = chain_next;
               if (last_ff) begin
                  buf_in = pad_buf(buf_ff, 6'd0);
                  buf_in[14] = '0;
                  buf_in[15] = {count_ff[28:0], 3'b000};
                  state_in = ST_PAD2;
                  last_in  = 1'b1;
               end else state_in = ST_IDLE;
            end
         end
         ST_PAD1, ST_PAD2: begin
            if (last_ff) begin
               ctl.start = 1'b1;
               last_in   = 1'b0;
            end else if (sts.done) begin
               chain_in = chain_next;
               if (state_ff == ST_PAD1) begin
                  buf_in     = '0;
                  buf_in[15] = {count_ff[28:0], 3'b000};
                  last_in    = 1'b1;
                  state_in   = ST_PAD2;
               end else begin
                  out_in = {chain_next[0], chain_next[1], chain_next[2], chain_next[3],
                            chain_next[4], chain_next[5], chain_next[6], chain_next[7],
                            1'b0};
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
               chain_in = SM3_IV;
               count_in = '0;
               ovf_in   = 1'b0;
               last_in  = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         chain_ff  <= SM3_IV;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         last_ff   <= 1'b0;
         blk_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         chain_ff  <= chain_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
         blk_go_ff <= (state_ff == ST_IDLE) && (state_in == ST_BLK);
      end
   end

endmodule
